// ===== design/kts_pkg.sv =====
// kts_pkg: shared types, constants and codes for the keyframe track sampler
// no dependencies; used by kts_dp, kts_ctrl and keyframe_track_lerp_sampler
package kts_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_AW    = $clog2(MAX_KEYS);
	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int KC_W      = 7;

	// item codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic CFG_KEY_COUNT = 1'b0;
	localparam logic CFG_EMPTY     = 1'b1;

	// result source codes
	localparam logic [1:0] SRC_EMPTY  = 2'd0;
	localparam logic [1:0] SRC_FIRST  = 2'd1;
	localparam logic [1:0] SRC_LAST   = 2'd2;
	localparam logic [1:0] SRC_INTERP = 2'd3;

	// output value selection
	typedef enum logic [1:0] {
		PICK_EMPTY = 2'd0,
		PICK_RD    = 2'd1,
		PICK_LAST  = 2'd2,
		PICK_RES   = 2'd3
	} pick_t;

	typedef struct packed {
		logic        action;
		logic [5:0]  key_index;
		logic [31:0] key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0] sample_time;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]  source;
	} out_t;

	// one stored keyframe
	typedef struct packed {
		logic [31:0] ktime;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	typedef struct packed {
		logic              wr;
		logic              ld_t;
		logic              ld_prev;
		logic              ld_last;
		logic              ld_next;
		logic              div_init;
		logic              div_step;
		logic              mul_step;
		logic [1:0]        comp;
		logic              out_ld;
		pick_t             pick;
		logic [1:0]        src;
		logic [KEY_AW-1:0] raddr;
	} cmd_t;

	typedef struct packed {
		logic t_le_rd;
		logic t_ge_rd;
		logic bracket;
	} sts_t;

endpackage

// ===== design/kts_ram.sv =====
// kts_ram: generic single write port, single read port RAM with registered read
// no dependencies
module kts_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/kts_dp.sv =====
// kts_dp: key store, comparators, serial divider, lerp multiplier, result register
// depends on kts_pkg and kts_ram
module kts_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  kts_pkg::in_t   item,
	input  kts_pkg::cmd_t  cmd,
	input  logic           cfg_valid,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data,
	output kts_pkg::sts_t  sts,
	output kts_pkg::out_t  result,
	output logic           done
);

	kts_pkg::key_t rd;
	kts_pkg::key_t wkey;
	kts_pkg::key_t prev_q, last_q, next_q;
	logic [kts_pkg::KEY_W-1:0] rdata;
	logic [31:0] t_q, empty_q;
	logic [31:0] span_q;
	logic [32:0] rem_q;
	logic [kts_pkg::DIV_STEPS-1:0] quo_q;
	logic [31:0] res_q [3];
	logic        wr_ok;

	assign wkey  = '{ktime: item.key_time, x: item.key_x, y: item.key_y, z: item.key_z};
	assign wr_ok = cmd.wr && (32'(item.key_index) < 32'(kts_pkg::MAX_KEYS));

	kts_ram #(.W(kts_pkg::KEY_W), .D(kts_pkg::MAX_KEYS)) u_keys (
		.clk  (clk),
		.we   (wr_ok),
		.waddr(item.key_index[kts_pkg::KEY_AW-1:0]),
		.wdata(wkey),
		.raddr(cmd.raddr),
		.rdata(rdata)
	);
	assign rd = rdata;

	// comparisons against the key just read
	assign sts.t_le_rd = t_q <= rd.ktime;
	assign sts.t_ge_rd = t_q >= rd.ktime;
	assign sts.bracket = (t_q >= prev_q.ktime) && (t_q <= rd.ktime);

	// restoring divider step
	logic        ge;
	logic [32:0] rem_sub;
	assign ge      = rem_q >= {1'b0, span_q};
	assign rem_sub = ge ? rem_q - {1'b0, span_q} : rem_q;

	// lerp of one component
	logic [31:0] a, b;
	logic signed [32:0] diff;
	logic signed [kts_pkg::DIV_STEPS:0] pmul;
	logic signed [kts_pkg::DIV_STEPS+33:0] prod;
	always_comb begin
		case (cmd.comp)
			2'd0:    begin a = prev_q.x; b = next_q.x; end
			2'd1:    begin a = prev_q.y; b = next_q.y; end
			default: begin a = prev_q.z; b = next_q.z; end
		endcase
	end
	assign diff = $signed({b[31], b}) - $signed({a[31], a});
	assign pmul = (span_q == '0) ? '0 : $signed({1'b0, quo_q});
	assign prod = diff * pmul;

	// operand and working registers
	always_ff @(posedge clk) begin
		if (cmd.ld_t)    t_q    <= item.sample_time;
		if (cmd.ld_prev) prev_q <= rd;
		if (cmd.ld_last) last_q <= rd;
		if (cmd.ld_next) next_q <= rd;
		if (cmd.div_init) begin
			span_q <= rd.ktime - prev_q.ktime;
			rem_q  <= {1'b0, t_q - prev_q.ktime};
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[kts_pkg::DIV_STEPS-2:0], ge};
			rem_q <= {rem_sub[31:0], 1'b0};
		end
		if (cmd.mul_step) begin
			res_q[cmd.comp] <= a + prod[kts_pkg::FRAC_BITS +: 32];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			result.source <= cmd.src;
			case (cmd.pick)
				kts_pkg::PICK_EMPTY: begin
					result.out_x <= empty_q; result.out_y <= empty_q; result.out_z <= empty_q;
				end
				kts_pkg::PICK_RD: begin
					result.out_x <= rd.x; result.out_y <= rd.y; result.out_z <= rd.z;
				end
				kts_pkg::PICK_LAST: begin
					result.out_x <= last_q.x; result.out_y <= last_q.y; result.out_z <= last_q.z;
				end
				default: begin
					result.out_x <= res_q[0]; result.out_y <= res_q[1];
					result.out_z <= res_q[2];
				end
			endcase
		end
	end

	// strobe and empty value register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done    <= 1'b0;
			empty_q <= '0;
		end else begin
			done <= cmd.out_ld;
			if (cfg_valid && cfg_index == kts_pkg::CFG_EMPTY) empty_q <= cfg_data;
		end
	end

endmodule

// ===== design/kts_ctrl.sv =====
// kts_ctrl: sequencer for key writes, clamp checks, key scan, divide and multiply
// depends on kts_pkg
module kts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          action,
	input  logic          cfg_valid,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	input  kts_pkg::sts_t sts,
	output kts_pkg::cmd_t cmd,
	output logic          busy
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_CHK_FIRST = 7'b0000010,
		S_CHK_LAST  = 7'b0000100,
		S_SCAN      = 7'b0001000,
		S_DIV       = 7'b0010000,
		S_MUL       = 7'b0100000,
		S_OUT       = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [kts_pkg::KC_W-1:0]   count_q, n;
	logic [kts_pkg::KEY_AW-1:0] idx_q, idx_d, last;
	logic [kts_pkg::CNT_W-1:0]  cnt_q, cnt_d;

	// effective key count and last slot
	assign n    = (count_q > kts_pkg::KC_W'(kts_pkg::MAX_KEYS)) ?
	              kts_pkg::KC_W'(kts_pkg::MAX_KEYS) : count_q;
	assign last = kts_pkg::KEY_AW'(n - 1'b1);
	assign busy = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.pick = kts_pkg::PICK_EMPTY;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action == kts_pkg::ACT_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.ld_t = 1'b1;
						if (n == '0) begin
							cmd.out_ld = 1'b1;
							cmd.pick   = kts_pkg::PICK_EMPTY;
							cmd.src    = kts_pkg::SRC_EMPTY;
						end else begin
							cmd.raddr = '0;
							state_d   = S_CHK_FIRST;
						end
					end
				end
			end
			S_CHK_FIRST: begin
				if (sts.t_le_rd) begin
					cmd.out_ld = 1'b1;
					cmd.pick   = kts_pkg::PICK_RD;
					cmd.src    = kts_pkg::SRC_FIRST;
					state_d    = S_IDLE;
				end else begin
					cmd.ld_prev = 1'b1;
					cmd.raddr   = last;
					state_d     = S_CHK_LAST;
				end
			end
			S_CHK_LAST: begin
				cmd.ld_last = 1'b1;
				if (sts.t_ge_rd) begin
					cmd.out_ld = 1'b1;
					cmd.pick   = kts_pkg::PICK_RD;
					cmd.src    = kts_pkg::SRC_LAST;
					state_d    = S_IDLE;
				end else begin
					cmd.raddr = kts_pkg::KEY_AW'(1);
					idx_d     = kts_pkg::KEY_AW'(1);
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.bracket) begin
					cmd.ld_next  = 1'b1;
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end else if (idx_q == last) begin
					cmd.out_ld = 1'b1;
					cmd.pick   = kts_pkg::PICK_LAST;
					cmd.src    = kts_pkg::SRC_LAST;
					state_d    = S_IDLE;
				end else begin
					cmd.ld_prev = 1'b1;
					cmd.raddr   = idx_q + 1'b1;
					idx_d       = idx_q + 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == kts_pkg::CNT_W'(kts_pkg::DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.comp     = cnt_q[1:0];
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == kts_pkg::CNT_W'(2)) state_d = S_OUT;
			end
			S_OUT: begin
				cmd.out_ld = 1'b1;
				cmd.pick   = kts_pkg::PICK_RES;
				cmd.src    = kts_pkg::SRC_INTERP;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, counters and key count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_index == kts_pkg::CFG_KEY_COUNT) begin
				count_q <= cfg_data[kts_pkg::KC_W-1:0];
			end
		end
	end

endmodule

// ===== design/keyframe_track_lerp_sampler.sv =====
// keyframe_track_lerp_sampler: samples a keyframe track with linear interpolation
// write item: busy stays low; a sample item returns the empty value when no keys are set, else
// checks the first key, then the last key, then scans keys, divides and multiplies x, y and z
// when interpolated (one key read per cycle, one quotient bit per cycle)
// busy falls as the result strobe rises, so the next item may start then; no receiver stall
// reset clears control state, key count, empty value and done; key store is undefined until written
module keyframe_track_lerp_sampler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kts_pkg::in_t  item,
	output logic          done,
	output kts_pkg::out_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);

	kts_pkg::cmd_t cmd;
	kts_pkg::sts_t sts;
	logic          cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	kts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.action   (item.action),
		.cfg_valid(cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	kts_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.cfg_valid(cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sts      (sts),
		.result   (result),
		.done     (done)
	);

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for keyframe_track_lerp_sampler
// drives write and sample items, predicts each sample result and checks it
// depends on design/kts_pkg.sv and design/keyframe_track_lerp_sampler.sv
`timescale 1ns / 1ps

module tb_top;
	import kts_pkg::*;

	// predicted track state and expected sample results
	class track_scoreboard;
		logic [31:0] key_times [MAX_KEYS];
		logic [31:0] key_xs [MAX_KEYS];
		logic [31:0] key_ys [MAX_KEYS];
		logic [31:0] key_zs [MAX_KEYS];
		logic [6:0]  count;
		logic [31:0] empty_val;
		out_t        pending [$];
		int          errors;
		int          samples;
		int          interps;

		function new();
			count = 0;
			empty_val = 0;
			errors = 0;
			samples = 0;
			interps = 0;
			for (int i = 0; i < MAX_KEYS; i++) begin
				key_times[i] = 0;
				key_xs[i] = 0;
				key_ys[i] = 0;
				key_zs[i] = 0;
			end
		endfunction

		function void set_reg(logic idx, logic [31:0] data);
			if (idx == CFG_KEY_COUNT)
				count = data[6:0];
			else
				empty_val = data;
		endfunction

		// exact floor of a + (b - a) * p / 2^FRAC_BITS
		function logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint p);
			longint sa, diff, prod, q;
			sa = longint'(signed'(a));
			diff = longint'(signed'(b)) - sa;
			prod = diff * p;
			if (prod >= 0)
				q = prod >>> FRAC_BITS;
			else
				q = -((-prod + (64'd1 << FRAC_BITS) - 1) >>> FRAC_BITS);
			return 32'(sa + q);
		endfunction

		function void note_item(in_t it);
			int          n;
			int          last;
			logic [31:0] t;
			logic [31:0] t0;
			logic [31:0] t1;
			longint      span;
			longint      p;
			out_t        r;
			bit          hit;
			if (it.action == ACT_WRITE) begin
				key_times[it.key_index] = it.key_time;
				key_xs[it.key_index] = it.key_x;
				key_ys[it.key_index] = it.key_y;
				key_zs[it.key_index] = it.key_z;
				return;
			end
			samples++;
			t = it.sample_time;
			n = (count > MAX_KEYS) ? MAX_KEYS : count;
			hit = 0;
			if (n == 0) begin
				r = '{empty_val, empty_val, empty_val, SRC_EMPTY};
			end else if (t <= key_times[0]) begin
				r = '{key_xs[0], key_ys[0], key_zs[0], SRC_FIRST};
			end else begin
				last = n - 1;
				if (t < key_times[last]) begin
					for (int i = 0; i + 1 < n && !hit; i++) begin
						t0 = key_times[i];
						t1 = key_times[i + 1];
						if (t >= t0 && t <= t1) begin
							span = longint'(t1 - t0);
							p = 0;
							if (span != 0)
								p = (longint'(t - t0) << FRAC_BITS) / span;
							r = '{blend(key_xs[i], key_xs[i + 1], p),
								blend(key_ys[i], key_ys[i + 1], p),
								blend(key_zs[i], key_zs[i + 1], p), SRC_INTERP};
							hit = 1;
							interps++;
						end
					end
				end
				if (!hit)
					r = '{key_xs[last], key_ys[last], key_zs[last], SRC_LAST};
			end
			pending = {pending, r};
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.out_x !== exp_r.out_x) begin
				$display("%0t: out_x expected %h actual %h", $time, exp_r.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp_r.out_y) begin
				$display("%0t: out_y expected %h actual %h", $time, exp_r.out_y, got.out_y);
				errors++;
			end
			if (got.out_z !== exp_r.out_z) begin
				$display("%0t: out_z expected %h actual %h", $time, exp_r.out_z, got.out_z);
				errors++;
			end
			if (got.source !== exp_r.source) begin
				$display("%0t: source expected %0d actual %0d", $time, exp_r.source,
					got.source);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         item;
	logic        done;
	out_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	track_scoreboard sb;
	int              gap_pct;
	int              item_total;

	keyframe_track_lerp_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// results are sampled at the edge that ends their strobe cycle
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// one register write, with cfg_valid lowered again before anything else
	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// hold one item until accepted, with a random gap first; start is left
	// high after acceptance and lowered by the next gap or by drain
	task automatic send_item(in_t it);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(it);
		item_total++;
	endtask

	task automatic put_key(int idx, logic [31:0] kt, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		in_t it;
		it = '{ACT_WRITE, 6'(idx), kt, x, y, z, $urandom};
		send_item(it);
	endtask

	task automatic sample_at(logic [31:0] t);
		in_t it;
		it = '{ACT_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, t};
		send_item(it);
	endtask

	// wait out outstanding results, then the pipeline tail
	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (150)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// ascending track of n keys with random spacing, occasional equal times
	task automatic build_track(int n, bit wide);
		logic [31:0] t;
		t = $urandom_range(wide ? 32'h4000_0000 : 1000);
		for (int i = 0; i < n; i++) begin
			put_key(i, t, rand_val(), rand_val(), rand_val());
			if ($urandom_range(7) != 0)
				t = t + (wide ? $urandom_range(32'h0300_0000) : $urandom_range(1, 5000));
		end
	endtask

	function automatic logic [31:0] pick_time(int n);
		int k;
		k = $urandom_range(n - 1);
		case ($urandom_range(4))
			0: return $urandom;
			1: return sb.key_times[k];
			default: return sb.key_times[k] + $urandom_range(3000);
		endcase
	endfunction

	initial begin
		int n;
		sb = new();
		arst_n = 0;
		start = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = CFG_KEY_COUNT;
		cfg_data = 0;
		gap_pct = 26;
		item_total = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty track with reset and extreme empty values
		sample_at(0);
		sample_at(32'hffff_ffff);
		drain();
		write_reg(CFG_EMPTY, 32'h0001_0000);
		sample_at(12345);
		drain();
		write_reg(CFG_EMPTY, 32'h8000_0000);
		sample_at(0);
		drain();

		// single key: at, before and after its time
		put_key(0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
		drain();
		write_reg(CFG_KEY_COUNT, 1);
		sample_at(32'h0001_0000);
		sample_at(0);
		sample_at(32'hffff_ffff);

		// extreme keys, full-range interpolation, zero span, unordered keys
		put_key(1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		put_key(2, 32'hffff_ffff, 1, 2, 3);
		put_key(3, 32'h0000_0005, 5, 6, 7);
		put_key(63, 32'hffff_ffff, 9, 9, 9);
		drain();
		write_reg(CFG_KEY_COUNT, 2);
		sample_at(32'h0001_0001);
		sample_at(32'h8000_0000);
		sample_at(32'hffff_fffe);
		drain();
		write_reg(CFG_KEY_COUNT, 4);
		sample_at(32'h0002_0000);
		sample_at(32'hffff_ffff);
		drain();
		write_reg(CFG_EMPTY, 32'h7fff_ffff);

		// random tracks; sender gaps at two rates, then no gap
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 26 : (ph == 1) ? 54 : 0;
			for (int trk = 0; trk < 6; trk++) begin
				drain();
				case ($urandom_range(5))
					0: n = 64;
					1: n = $urandom_range(2, 64);
					default: n = $urandom_range(2, 10);
				endcase
				build_track(n, $urandom_range(1));
				if ($urandom_range(5) == 0)
					put_key($urandom_range(n - 1), $urandom, $urandom, $urandom, $urandom);
				drain();
				write_reg(CFG_KEY_COUNT, (n == 64 && $urandom_range(1)) ? 7'd127 : 7'(n));
				if ($urandom_range(3) == 0) begin
					write_reg(CFG_EMPTY, $urandom);
					drain();
				end
				for (int s = 0; s < 18; s++)
					sample_at(pick_time(n));
			end
			// one empty-track sample per phase
			drain();
			write_reg(CFG_KEY_COUNT, 0);
			sample_at($urandom);
		end

		drain();
		$display("covered %0d items, %0d samples, %0d interpolated, across empty,",
			item_total, sb.samples, sb.interps);
		$display("single-key, full-range, zero-span, unordered and 64-key tracks");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
